// ===== hw/rtl/wtmt_pkg.sv =====
package wtmt_pkg;

    localparam int TYPE_BITS       = 8;
    localparam int MAX_MEMBERS     = 4;
    localparam int NUM_POS         = 4;
    localparam int NUM_PERM        = 6;
    localparam int TABLE_DEPTH_DEF = 256;

    localparam int IDX_W      = 8;
    localparam int PARAM_W    = 64;
    localparam int KIND_W     = 2;
    localparam int WC_W       = 3;
    localparam int PCODE_W    = 3;
    localparam int MC_W       = 3;
    localparam int EC_W       = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int SCNT_W     = $clog2(2 * NUM_POS + 1);
    localparam int PCNT_W     = $clog2(NUM_POS + 1);

    typedef logic [TYPE_BITS-1:0] t_type;
    typedef logic [1:0]           t_pos;

    localparam t_type WILDCARD = '1;

    // entry position compared against each query position, per ordering
    localparam t_pos PERM_SRC [NUM_PERM][NUM_POS] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd3, 2'd2},
        '{2'd2, 2'd1, 2'd0, 2'd3},
        '{2'd2, 2'd1, 2'd3, 2'd0},
        '{2'd3, 2'd1, 2'd0, 2'd2},
        '{2'd3, 2'd1, 2'd2, 2'd0}
    };

    localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERMUTE_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REORDER_ENABLE = 3'd4;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FWD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REV  = 2'd2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   entry_index;
        t_type              type_zero;
        t_type              type_one;
        t_type              type_two;
        t_type              type_three;
        logic [PARAM_W-1:0] param_word;
    } t_req;

    typedef struct packed {
        logic [KIND_W-1:0]  found_kind;
        logic [IDX_W-1:0]   match_index;
        logic [PARAM_W-1:0] param_out;
        logic [WC_W-1:0]    wildcard_count;
        logic [PCODE_W-1:0] perm_code;
    } t_res;

    typedef struct packed {
        logic                             valid;
        t_type [NUM_POS-1:0]              types;
        logic [PARAM_W-1:0]               param;
        logic [SCNT_W-1:0]                scnt;
        logic [SCNT_W-1:0]                rcnt;
        logic [WC_W-1:0]                  wc;
        logic [NUM_PERM-1:0][PCNT_W-1:0]  pcnt;
    } t_cell_bus;

    typedef struct packed {
        logic                flush;
        logic [MC_W-1:0]     n;
        t_type [NUM_POS-1:0] query;
        t_type [NUM_POS-1:0] rquery;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/wildcard_tuple_match_table_top.sv =====
// Load request: result strobe in the cycle after accept; busy stays low.
// Lookup: entries stream one per cycle from the table memory read stage into a
// four-cell compare chain; the strobe is registered from the chain tail on the first hit,
// else on the last entry searched; an empty search strobes in the cycle after accept.
// The next request is taken the cycle its result is shown; results cannot be stalled.
// Synchronous active-low reset restores register defaults; table is undefined until loaded.
module wildcard_tuple_match_table_top import wtmt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    output logic                  o_result_valid,
    output t_res                  o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [MC_W-1:0]     r_member_count;
    logic [EC_W-1:0]     r_entry_count;
    logic                r_rev_en;
    logic                r_perm_en;
    logic                r_reorder_en;

    t_state              r_state;
    t_state              n_state;
    t_type [NUM_POS-1:0] r_query;
    t_type [NUM_POS-1:0] r_rquery;
    logic [CW-1:0]       r_lim;
    logic [CW-1:0]       r_lim_m1;
    logic [CW-1:0]       r_addr;
    logic [CW-1:0]       r_out_cnt;
    logic                r_rd_vld;
    t_type [NUM_POS-1:0] r_rd_types;
    logic [PARAM_W-1:0]  r_rd_param;
    logic                r_res_vld;
    t_res                r_res;

    t_type [NUM_POS-1:0] r_mem_types [TABLE_DEPTH];
    logic [PARAM_W-1:0]  r_mem_params [TABLE_DEPTH];

    logic [MC_W-1:0]     w_n;
    logic [CW-1:0]       w_lim;
    logic                w_accept;
    logic                w_load;
    logic                w_lookup;
    logic                w_load_ok;
    t_type [NUM_POS-1:0] w_q;
    t_type [NUM_POS-1:0] w_rq;
    logic                w_rd_en;
    t_cell_ctrl          w_ctrl;
    t_cell_bus           w_bus [NUM_POS+1];
    t_cell_bus           w_tail;
    logic                w_s_hit;
    logic                w_r_hit;
    logic [NUM_PERM-1:0] w_p_hit;
    logic [PCODE_W-1:0]  w_pidx;
    logic                w_hit;
    logic                w_finish;
    t_res                w_hit_res;

    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_res_vld;
    assign o_res          = r_res;

    assign w_n   = (r_member_count > MC_W'(MAX_MEMBERS)) ? MC_W'(MAX_MEMBERS) : r_member_count;
    assign w_lim = (int'(r_entry_count) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(r_entry_count);

    assign w_accept  = start & ~busy;
    assign w_load    = w_accept & (i_req.mode == MODE_LOAD);
    assign w_lookup  = w_accept & (i_req.mode == MODE_LOOKUP);
    assign w_load_ok = int'(i_req.entry_index) < TABLE_DEPTH;
    assign w_q       = {i_req.type_three, i_req.type_two, i_req.type_one, i_req.type_zero};
    assign w_rd_en   = (r_state == ST_SCAN) && (r_addr < r_lim);

    // query as seen by the reversed scan: rq[j] = q[n-1-j]
    always_comb begin
        for (int j = 0; j < NUM_POS; j++) begin
            w_rq[j] = '0;
            if (MC_W'(j) < w_n) begin
                w_rq[j] = w_q[2'(w_n - MC_W'(j) - MC_W'(1))];
            end
        end
    end

    always_comb begin
        w_ctrl.flush  = w_finish;
        w_ctrl.n      = w_n;
        w_ctrl.query  = r_query;
        w_ctrl.rquery = r_rquery;
    end

    always_comb begin
        w_bus[0]       = '0;
        w_bus[0].valid = r_rd_vld;
        w_bus[0].types = r_rd_types;
        w_bus[0].param = r_rd_param;
    end

    for (genvar k = 0; k < NUM_POS; k++) begin : g_cell
        wtmt_cell #(
            .POS (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_bus   (w_bus[k]),
            .o_bus   (w_bus[k+1])
        );
    end

    assign w_tail = w_bus[NUM_POS];

    // tail of the chain: first try that succeeds for this entry
    always_comb begin
        w_s_hit = w_tail.scnt == SCNT_W'(w_n);
        w_r_hit = r_rev_en && (w_tail.rcnt == SCNT_W'(w_n));
        for (int p = 0; p < NUM_PERM; p++) begin
            w_p_hit[p] = r_perm_en && (w_tail.pcnt[p] == PCNT_W'(w_n));
        end
        w_pidx = '0;
        for (int p = NUM_PERM - 1; p >= 0; p--) begin
            if (w_p_hit[p]) begin
                w_pidx = PCODE_W'(p);
            end
        end
        w_hit    = w_s_hit | w_r_hit | (|w_p_hit);
        w_finish = w_tail.valid && (w_hit || (r_out_cnt == r_lim_m1));

        w_hit_res = '0;
        w_hit_res.wildcard_count = w_tail.wc;
        if (w_hit) begin
            w_hit_res.match_index = IDX_W'(r_out_cnt);
            w_hit_res.param_out   = w_tail.param;
            if (w_s_hit) begin
                w_hit_res.found_kind = KIND_FWD;
            end else if (w_r_hit) begin
                w_hit_res.found_kind = KIND_REV;
            end else begin
                w_hit_res.found_kind = KIND_FWD;
                if (r_reorder_en) begin
                    w_hit_res.perm_code = w_pidx + PCODE_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (w_lookup && (w_lim != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_rd_vld       <= 1'b0;
            r_res_vld      <= 1'b0;
            r_addr         <= '0;
            r_out_cnt      <= '0;
            r_member_count <= MC_W'(4);
            r_entry_count  <= '0;
            r_rev_en       <= 1'b1;
            r_perm_en      <= 1'b0;
            r_reorder_en   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= w_load | (w_lookup & (w_lim == '0)) | w_finish;
            r_rd_vld  <= w_rd_en & ~w_finish;
            if (w_lookup) begin
                r_addr <= '0;
            end else if (w_rd_en) begin
                r_addr <= r_addr + CW'(1);
            end
            if (w_lookup) begin
                r_out_cnt <= '0;
            end else if (w_tail.valid) begin
                r_out_cnt <= r_out_cnt + CW'(1);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MEMBER_COUNT:   r_member_count <= i_cfg_data[MC_W-1:0];
                    CFG_ENTRY_COUNT:    r_entry_count  <= i_cfg_data[EC_W-1:0];
                    CFG_REVERSE_ENABLE: r_rev_en       <= i_cfg_data[0];
                    CFG_PERMUTE_ENABLE: r_perm_en      <= i_cfg_data[0];
                    CFG_REORDER_ENABLE: r_reorder_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lookup) begin
            r_query  <= w_q;
            r_rquery <= w_rq;
            r_lim    <= w_lim;
            r_lim_m1 <= w_lim - CW'(1);
        end
        if (w_load || w_lookup) begin
            r_res <= '0;
        end else if (w_finish) begin
            r_res <= w_hit_res;
        end
    end

    // table memory: one write port for loads, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (w_load && w_load_ok) begin
            r_mem_types[AW'(i_req.entry_index)]  <= w_q;
            r_mem_params[AW'(i_req.entry_index)] <= i_req.param_word;
        end
        if (w_rd_en) begin
            r_rd_types <= r_mem_types[r_addr[AW-1:0]];
            r_rd_param <= r_mem_params[r_addr[AW-1:0]];
        end
    end

    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> (r_state == ST_SCAN))
        else $error("compare chain output outside a lookup");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_addr <= r_lim) && (r_out_cnt <= r_addr)))
        else $error("scan counters out of order");

    a_no_strobe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !o_result_valid)
        else $error("result strobe while a lookup is running");

    a_finish_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && w_finish) |=> (o_result_valid && !busy))
        else $error("finished lookup gave no result");

endmodule

// ===== hw/rtl/wtmt_cell.sv =====
module wtmt_cell import wtmt_pkg::*; #(
    parameter int POS = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_cell_bus  i_bus,
    output t_cell_bus  o_bus
);

    t_cell_bus r_data;
    t_cell_bus n_data;
    logic      r_valid;
    logic      w_active;
    logic      w_eq;
    logic      w_wild;
    logic      w_req;

    // one type position: straight, reversed and all orderings advance here
    always_comb begin
        n_data   = i_bus;
        w_active = MC_W'(POS) < i_ctrl.n;
        w_eq     = i_ctrl.query[POS] == i_bus.types[POS];
        w_wild   = i_bus.types[POS] == WILDCARD;
        w_req    = i_ctrl.rquery[POS] == i_bus.types[POS];
        if (w_active) begin
            n_data.scnt = i_bus.scnt + SCNT_W'(w_eq) + SCNT_W'(w_wild);
            n_data.rcnt = i_bus.rcnt + SCNT_W'(w_req) + SCNT_W'(w_wild);
            n_data.wc   = i_bus.wc + WC_W'(w_wild);
        end
        // orderings always use all four positions and ignore wildcards
        for (int p = 0; p < NUM_PERM; p++) begin
            n_data.pcnt[p] = i_bus.pcnt[p]
                + PCNT_W'(i_ctrl.query[POS] == i_bus.types[PERM_SRC[p][POS]]);
        end
        n_data.valid = i_bus.valid & ~i_ctrl.flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_comb begin
        o_bus       = r_data;
        o_bus.valid = r_valid;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import wtmt_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int IDLE_PAUSE  = 4;
    localparam int DRAIN_TAIL  = 16;
    localparam int PHASES      = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

    // entry position feeding query positions 0, 2 and 3, per ordering
    localparam int PERM_ORDER [NUM_PERM][3] = '{
        '{0, 2, 3}, '{0, 3, 2}, '{2, 0, 3}, '{2, 3, 0}, '{3, 0, 2}, '{3, 2, 0}
    };

    localparam int PHASE_ENTRIES [PHASES] = '{4, 16, 256, 1, 0, 8, 32, 3, 511, 12, 6, 2};
    localparam int PHASE_MEMBERS [PHASES] = '{4, 2, 4, 3, 4, 7, 0, 1, 4, 2, 5, 4};

    typedef t_type tuple_t [NUM_POS];

    class match_board;
        tuple_t             entry_codes [TABLE_DEPTH_DEF];
        logic [PARAM_W-1:0] entry_words [TABLE_DEPTH_DEF];
        bit                 loaded      [TABLE_DEPTH_DEF];
        logic [MC_W-1:0]    member_count = 3'd4;
        logic [EC_W-1:0]    entry_count  = '0;
        bit                 reverse_on   = 1'b1;
        bit                 permute_on   = 1'b0;
        bit                 reorder_on   = 1'b0;
        t_res               expected_matches [$];
        int                 errors = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MEMBER_COUNT:   member_count = data[MC_W-1:0];
                CFG_ENTRY_COUNT:    entry_count  = data[EC_W-1:0];
                CFG_REVERSE_ENABLE: reverse_on   = data[0];
                CFG_PERMUTE_ENABLE: permute_on   = data[0];
                CFG_REORDER_ENABLE: reorder_on   = data[0];
                default: ;
            endcase
        endfunction

        function int scan_hits(tuple_t q, tuple_t e, int n, bit rev, output int wild);
            int    hits = 0;
            t_type qi;
            wild = 0;
            for (int j = 0; j < n; j++) begin
                qi = rev ? q[n - 1 - j] : q[j];
                if (qi == e[j]) hits++;
                if (e[j] == WILDCARD) begin
                    hits++;
                    wild++;
                end
            end
            return hits;
        endfunction

        // permuted tries always compare all four positions, no wildcards
        function int perm_hits(tuple_t q, tuple_t e, int p);
            return int'(q[0] == e[PERM_ORDER[p][0]]) + int'(q[1] == e[1]) +
                   int'(q[2] == e[PERM_ORDER[p][1]]) + int'(q[3] == e[PERM_ORDER[p][2]]);
        endfunction

        function t_res predict_match(t_req r);
            t_res               res;
            tuple_t             q;
            tuple_t             e;
            int                 n;
            int                 lim;
            int                 wc;
            logic [KIND_W-1:0]  kind;
            logic [PCODE_W-1:0] code;
            res = '0;
            q[0] = r.type_zero;
            q[1] = r.type_one;
            q[2] = r.type_two;
            q[3] = r.type_three;
            if (r.mode == MODE_LOAD) begin
                entry_codes[r.entry_index] = q;
                entry_words[r.entry_index] = r.param_word;
                loaded[r.entry_index] = 1'b1;
                return res;
            end
            n   = member_count > MAX_MEMBERS ? MAX_MEMBERS : member_count;
            lim = entry_count > TABLE_DEPTH_DEF ? TABLE_DEPTH_DEF : entry_count;
            wc  = 0;
            for (int i = 0; i < lim; i++) begin
                e = entry_codes[i];
                kind = KIND_NONE;
                code = '0;
                if (scan_hits(q, e, n, 1'b0, wc) == n) begin
                    kind = KIND_FWD;
                end else if (reverse_on && scan_hits(q, e, n, 1'b1, wc) == n) begin
                    kind = KIND_REV;
                end else if (permute_on) begin
                    for (int p = 0; p < NUM_PERM; p++) begin
                        if (perm_hits(q, e, p) == n) begin
                            kind = KIND_FWD;
                            code = reorder_on ? PCODE_W'(p + 1) : '0;
                            break;
                        end
                    end
                end
                if (kind != KIND_NONE) begin
                    res.found_kind  = kind;
                    res.match_index = IDX_W'(i);
                    res.param_out   = entry_words[i];
                    res.perm_code   = code;
                    break;
                end
            end
            res.wildcard_count = WC_W'(wc);
            return res;
        endfunction

        function void note_request(t_req r);
            expected_matches.push_back(predict_match(r));
        endfunction

        function void check_result(t_res got);
            t_res exp_res;
            if (expected_matches.size() == 0) begin
                $error("result with nothing pending: %p", got);
                errors++;
                return;
            end
            exp_res = expected_matches.pop_front();
            if (got.found_kind !== exp_res.found_kind) begin
                $error("found_kind: expected %0d, got %0d", exp_res.found_kind, got.found_kind);
                errors++;
            end
            if (got.match_index !== exp_res.match_index) begin
                $error("match_index: expected %0d, got %0d",
                       exp_res.match_index, got.match_index);
                errors++;
            end
            if (got.param_out !== exp_res.param_out) begin
                $error("param_out: expected %h, got %h", exp_res.param_out, got.param_out);
                errors++;
            end
            if (got.wildcard_count !== exp_res.wildcard_count) begin
                $error("wildcard_count: expected %0d, got %0d",
                       exp_res.wildcard_count, got.wildcard_count);
                errors++;
            end
            if (got.perm_code !== exp_res.perm_code) begin
                $error("perm_code: expected %0d, got %0d", exp_res.perm_code, got.perm_code);
                errors++;
            end
        endfunction

        function int pending_count();
            return expected_matches.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    logic                  o_result_valid;
    t_res                  o_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    match_board board = new;
    int         burst_left = 0;
    int         stall_cycles = 0;

    wildcard_tuple_match_table_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .o_result_valid (o_result_valid),
        .o_res          (o_res),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            board.check_result(o_res);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("wildcard_tuple_match_table_top test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // mostly a small alphabet so lookups hit often
    function automatic t_type pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return WILDCARD;
        if (r < 85) return t_type'($urandom_range(1, 4));
        return t_type'($urandom_range(0, 255));
    endfunction

    function automatic t_req make_req(logic mode, int idx, t_type a, t_type b, t_type c,
                                      t_type d, logic [PARAM_W-1:0] word);
        t_req r;
        r.mode        = mode;
        r.entry_index = IDX_W'(idx);
        r.type_zero   = a;
        r.type_one    = b;
        r.type_two    = c;
        r.type_three  = d;
        r.param_word  = word;
        return r;
    endfunction

    function automatic t_req load_request(int idx);
        bit wide;
        wide = ($urandom_range(0, 9) == 0);
        return make_req(MODE_LOAD, idx,
                        wide ? t_type'($urandom) : pick_code(),
                        wide ? t_type'($urandom) : pick_code(),
                        wide ? t_type'($urandom) : pick_code(),
                        wide ? t_type'($urandom) : pick_code(),
                        {$urandom, $urandom});
    endfunction

    // some loads, else lookups mostly built from a live entry: straight, reversed or permuted
    function automatic t_req random_request(int lim, int n);
        tuple_t q;
        tuple_t e;
        int     sel;
        int     p;
        if ($urandom_range(0, 99) < 30) begin
            if (lim > 0 && $urandom_range(0, 9) < 7) return load_request($urandom_range(0, lim - 1));
            return load_request($urandom_range(0, 255));
        end
        sel = $urandom_range(0, 99);
        for (int j = 0; j < NUM_POS; j++) q[j] = pick_code();
        if (lim == 0 || sel >= 85) begin
            for (int j = 0; j < NUM_POS; j++) q[j] = t_type'($urandom);
        end else begin
            e = board.entry_codes[$urandom_range(0, lim - 1)];
            if (sel < 40) begin
                for (int j = 0; j < n; j++) if (e[j] != WILDCARD) q[j] = e[j];
            end else if (sel < 65) begin
                for (int j = 0; j < n; j++) if (e[j] != WILDCARD) q[n - 1 - j] = e[j];
            end else begin
                p = $urandom_range(0, NUM_PERM - 1);
                q[0] = e[PERM_ORDER[p][0]];
                q[1] = e[1];
                q[2] = e[PERM_ORDER[p][1]];
                q[3] = e[PERM_ORDER[p][2]];
            end
            if ($urandom_range(0, 4) == 0) q[$urandom_range(0, 3)] = pick_code();
        end
        return make_req(MODE_LOOKUP, $urandom_range(0, 255), q[0], q[1], q[2], q[3],
                        {$urandom, $urandom});
    endfunction

    task automatic send_req(input t_req r);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else if ($urandom_range(0, 9) == 0) begin
            gap = 0;
            burst_left = $urandom_range(5, 30);
        end else begin
            gap = $urandom_range(0, 15);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        board.note_request(r);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    // writes all registers back to back, then one unmapped index
    task automatic program_regs(int mc, int ec, bit rv, bit pm, bit ro, bit noisy);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        logic [CFG_DATA_W-1:0] noise;
        noise = noisy ? CFG_DATA_W'($urandom) : '0;
        idx = '{CFG_MEMBER_COUNT, CFG_ENTRY_COUNT, CFG_REVERSE_ENABLE, CFG_PERMUTE_ENABLE,
                CFG_REORDER_ENABLE, CFG_IDX_W'(CFG_SPARE + $urandom_range(0, 2))};
        val = '{{noise[8:3], MC_W'(mc)}, EC_W'(ec), {noise[8:1], rv}, {noise[8:1], pm},
                {noise[8:1], ro}, CFG_DATA_W'($urandom)};
        for (int k = 0; k < 6; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            board.write_reg(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int lim;
        int n;
        int mc;
        int ec;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty search with reset registers
        send_req(make_req(MODE_LOOKUP, 0, 1, 2, 3, 4, '1));
        send_req(make_req(MODE_LOAD, 0, 10, 20, 30, 40, '1));
        send_req(make_req(MODE_LOAD, 1, WILDCARD, 21, WILDCARD, 41, 64'h0123_4567_89ab_cdef));
        send_req(make_req(MODE_LOAD, 2, 50, 60, 70, 80, 64'h8000_0000_0000_0001));
        send_req(make_req(MODE_LOAD, 3, WILDCARD, WILDCARD, WILDCARD, WILDCARD, '0));
        send_req(make_req(MODE_LOAD, 255, 0, 0, 0, 0, 64'hffff_0000_ffff_0000));
        settle();
        program_regs(4, 4, 1, 1, 1, 0);
        send_req(make_req(MODE_LOOKUP, 0, 10, 20, 30, 40, '0));
        send_req(make_req(MODE_LOOKUP, 0, 40, 30, 20, 10, '0));
        send_req(make_req(MODE_LOOKUP, 0, 50, 60, 80, 70, '0));
        send_req(make_req(MODE_LOOKUP, 0, 70, 60, 50, 80, '0));
        send_req(make_req(MODE_LOOKUP, 0, 99, 21, 98, 41, '0));
        // query wildcards count twice against wildcard entries
        send_req(make_req(MODE_LOOKUP, 0, WILDCARD, WILDCARD, WILDCARD, WILDCARD, '0));
        send_req(make_req(MODE_LOOKUP, 0, 1, 2, 3, 4, '0));
        settle();
        program_regs(4, 3, 0, 1, 0, 0);
        send_req(make_req(MODE_LOOKUP, 0, 50, 60, 80, 70, '0));
        send_req(make_req(MODE_LOOKUP, 0, 40, 30, 20, 10, '0));
        send_req(make_req(MODE_LOOKUP, 0, 1, 2, 3, 4, '0));
        settle();
        program_regs(2, 4, 1, 0, 0, 1);
        send_req(make_req(MODE_LOOKUP, 0, 20, 10, 0, 0, '0));
        send_req(make_req(MODE_LOOKUP, 0, 10, 20, 7, 7, '0));
        settle();
        program_regs(0, 4, 1, 0, 0, 0);
        send_req(make_req(MODE_LOOKUP, 0, 5, 5, 5, 5, '0));
        settle();
        program_regs(7, 4, 1, 0, 0, 1);
        send_req(make_req(MODE_LOOKUP, 0, 10, 20, 30, 40, '0));
        settle();
        program_regs(1, 4, 1, 1, 1, 0);
        send_req(make_req(MODE_LOOKUP, 0, 10, 0, 0, 0, '0));

        for (int ph = 0; ph < PHASES; ph++) begin
            mc  = PHASE_MEMBERS[ph];
            ec  = PHASE_ENTRIES[ph];
            lim = ec > TABLE_DEPTH_DEF ? TABLE_DEPTH_DEF : ec;
            n   = mc > MAX_MEMBERS ? MAX_MEMBERS : mc;
            // every searched entry must hold data before the search can reach it
            for (int i = 0; i < lim; i++) begin
                if (!board.loaded[i]) send_req(load_request(i));
            end
            settle();
            if (ph == 0) program_regs(mc, ec, 1, 1, 1, 0);
            else if (ph == 1) program_regs(mc, ec, 0, 0, 0, 1);
            else program_regs(mc, ec, $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 1), ph % 2);
            repeat (lim > 64 ? 20 : 90) send_req(random_request(lim, n));
        end

        settle();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (board.errors == 0 && board.pending_count() == 0) begin
            $display("wildcard_tuple_match_table_top test passed");
        end else begin
            $display("wildcard_tuple_match_table_top test failed");
        end
        $finish;
    end

endmodule
